// File: hw/rtl/qat_pkg.sv
// Package for the quoted argument tokenizer: character codes, parse modes,
// result kinds and the structs passed between the tokenizer modules.
// No dependencies.
package qat_pkg;

   localparam int unsigned ARG_LIMIT_DEFAULT = 64;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned MODE_W  = 3;

   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;

   localparam logic [MODE_W-1:0] MODE_BLANK = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNQ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SQ    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DQ    = 3'd3;
   localparam logic [MODE_W-1:0] ESC_BIT    = 3'd4;

   localparam logic [KIND_W-1:0] KIND_LIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SEP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CH_W-1:0]    data;
      logic [COUNT_W-1:0] arg_count;
      logic               quote_error;
   } qat_result_type;

   typedef struct packed {
      logic               emit;
      qat_result_type     result;
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
   } qat_step_type;

endpackage

// File: hw/rtl/qat_if.sv
// Handshake interfaces for the tokenizer's byte channel and result channel.
// Depends on qat_pkg for field widths.
interface qat_req_if import qat_pkg::*;;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            line_end;

   modport source (output valid, ch, line_end, input ready);
   modport sink (input valid, ch, line_end, output ready);
endinterface

interface qat_rsp_if import qat_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CH_W-1:0]    data;
   logic [COUNT_W-1:0] arg_count;
   logic               quote_error;

   modport source (output valid, kind, data, arg_count, quote_error, input ready);
   modport sink (input valid, kind, data, arg_count, quote_error, output ready);
endinterface

// File: hw/rtl/qat_parse.sv
// Combinational parse step: next mode, next word count and the result for
// one byte. Depends on qat_pkg.
module qat_parse import qat_pkg::*; #(
   parameter int unsigned ARG_LIMIT = ARG_LIMIT_DEFAULT
) (
   input  logic [MODE_W-1:0]  mode,
   input  logic [COUNT_W-1:0] count,
   input  logic [CH_W-1:0]    ch,
   input  logic               line_end,
   output qat_step_type       step
);

   localparam int unsigned COUNT_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      (ARG_LIMIT > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(ARG_LIMIT);

   logic            eol;
   logic            blank;
   logic [CH_W-1:0] close_quote;

   assign eol         = line_end || (ch == CH_NUL);
   assign blank       = (ch == CH_SPACE) || (ch == CH_TAB);
   assign close_quote = (mode == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      step        = '0;
      step.mode   = mode;
      step.count  = count;
      if (eol) begin
         step.emit                = 1'b1;
         step.result.kind         = KIND_END;
         step.result.arg_count    = count;
         step.result.quote_error  = (mode != MODE_BLANK) && (mode != MODE_UNQ);
         step.mode                = MODE_BLANK;
         step.count               = '0;
      end else begin
         unique case (mode)
            MODE_BLANK: begin
               if (!blank) begin
                  if (count < COUNT_CAP) begin
                     step.count = count + COUNT_W'(1);
                  end
                  priority if (ch == CH_SQUOTE) begin
                     step.mode = MODE_SQ;
                  end else if (ch == CH_DQUOTE) begin
                     step.mode = MODE_DQ;
                  end else if (ch == CH_BSLASH) begin
                     step.mode = MODE_UNQ | ESC_BIT;
                  end else begin
                     step.mode        = MODE_UNQ;
                     step.emit        = 1'b1;
                     step.result.kind = KIND_LIT;
                     step.result.data = ch;
                  end
               end
            end
            MODE_UNQ: begin
               priority if (ch == CH_SQUOTE) begin
                  step.mode = MODE_SQ;
               end else if (ch == CH_DQUOTE) begin
                  step.mode = MODE_DQ;
               end else if (ch == CH_BSLASH) begin
                  step.mode = MODE_UNQ | ESC_BIT;
               end else if (blank) begin
                  step.mode        = MODE_BLANK;
                  step.emit        = 1'b1;
                  step.result.kind = KIND_SEP;
               end else begin
                  step.emit        = 1'b1;
                  step.result.kind = KIND_LIT;
                  step.result.data = ch;
               end
            end
            MODE_SQ, MODE_DQ: begin
               priority if (ch == close_quote) begin
                  step.mode = MODE_UNQ;
               end else if (ch == CH_BSLASH) begin
                  step.mode = mode | ESC_BIT;
               end else begin
                  step.emit        = 1'b1;
                  step.result.kind = KIND_LIT;
                  step.result.data = ch;
               end
            end
            default: begin
               // Escaped modes: the byte is taken literally.
               step.mode        = mode ^ ESC_BIT;
               step.emit        = 1'b1;
               step.result.kind = KIND_LIT;
               step.result.data = ch;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/quoted_argument_tokenizer_unit.sv
// Quoted argument tokenizer, top level: input register, parse step and
// result register. Depends on qat_pkg, qat_if and qat_parse.
//
// The unit takes one command-line byte per cycle and returns literal
// characters, word separators and an end-of-line status with the word
// count and a quoting-error flag. An accepted byte goes from the input
// register through the parse step into the result register; the parse-state
// update is a loop of its own, so a new item is accepted every cycle as
// long as the result side keeps taking items. Bytes that produce no result
// leave the pipeline without occupying the result register.
module quoted_argument_tokenizer_unit import qat_pkg::*; #(
   parameter int unsigned ARG_LIMIT = ARG_LIMIT_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   qat_req_if.sink  req_chan,
   qat_rsp_if.source rsp_chan
);

   logic               in_valid_ff, in_valid_in;
   logic [CH_W-1:0]    in_ch_ff;
   logic               in_line_end_ff;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   qat_result_type     rsp_ff;

   logic         advance;
   logic         req_take;
   qat_step_type step;

   qat_parse #(
      .ARG_LIMIT(ARG_LIMIT)
   ) u_parse (
      .mode     (mode_ff),
      .count    (count_ff),
      .ch       (in_ch_ff),
      .line_end (in_line_end_ff),
      .step     (step)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      if (advance) begin
         rsp_valid_in = in_valid_ff && step.emit;
         if (in_valid_ff) begin
            mode_in  = step.mode;
            count_in = step.count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_BLANK;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff       <= req_chan.ch;
         in_line_end_ff <= req_chan.line_end;
      end
      if (advance && in_valid_ff && step.emit) begin
         rsp_ff <= step.result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_ff.kind;
   assign rsp_chan.data        = rsp_ff.data;
   assign rsp_chan.arg_count   = rsp_ff.arg_count;
   assign rsp_chan.quote_error = rsp_ff.quote_error;

endmodule

// File: hw/rtl/qat_checker.sv
// Port-level assertions for the quoted argument tokenizer and the bind that
// attaches them to the top level. Depends on qat_pkg.
module qat_checker import qat_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [KIND_W-1:0]  rsp_kind,
   input logic [CH_W-1:0]    rsp_data,
   input logic [COUNT_W-1:0] rsp_arg_count,
   input logic               rsp_quote_error
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result item dropped while stalled");

   property p_kind_legal;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_kind == KIND_LIT) || (rsp_kind == KIND_SEP) ||
                       (rsp_kind == KIND_END);
   endproperty
   a_kind_legal: assert property (p_kind_legal) else $error("illegal result kind");

   property p_status_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_kind != KIND_END) |-> (rsp_arg_count == '0) && !rsp_quote_error;
   endproperty
   a_status_zero: assert property (p_status_zero) else $error("status fields set on non-status item");

   property p_data_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && (rsp_kind != KIND_LIT) |-> (rsp_data == '0);
   endproperty
   a_data_zero: assert property (p_data_zero) else $error("data set on non-literal item");

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_qat_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_data        (rsp_chan.data),
   .rsp_arg_count   (rsp_chan.arg_count),
   .rsp_quote_error (rsp_chan.quote_error)
);
